@@ rtl/wscp_pkg.sv @@
// Package for the wall segment clip and project block.
// Holds register codes, reset values, line kinds, divider sizes and sideband types.
// Depends on nothing.
`default_nettype none

package wscp_pkg;

   // Configuration register indexes (byte address is four times the index).
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_FOCAL_LENGTH = 3'd0;
   localparam logic [2:0] REG_CENTER_X     = 3'd1;
   localparam logic [2:0] REG_CENTER_Y     = 3'd2;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd3;
   localparam logic [2:0] REG_EYE_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_NEAR_PLANE   = 3'd5;

   localparam logic [7:0] RST_FOCAL_LENGTH = 8'd48;
   localparam logic [7:0] RST_CENTER_X     = 8'd64;
   localparam logic [7:0] RST_CENTER_Y     = 8'd32;
   localparam logic [8:0] RST_SCREEN_WIDTH = 9'd128;
   localparam logic [7:0] RST_EYE_HEIGHT   = 8'd5;
   localparam logic [7:0] RST_NEAR_PLANE   = 8'd1;

   // Line kinds.
   localparam logic [2:0] KIND_CEILING    = 3'd0;
   localparam logic [2:0] KIND_FLOOR      = 3'd1;
   localparam logic [2:0] KIND_LEFT       = 3'd2;
   localparam logic [2:0] KIND_RIGHT      = 3'd3;
   localparam logic [2:0] KIND_FLOOR_STEP = 3'd4;
   localparam logic [2:0] KIND_CEIL_STEP  = 3'd5;

   localparam logic OP_SOLID = 1'b0;

   // Divider sizes: clip fraction and projection quotients.
   localparam int CLIP_DW = 48;
   localparam int CLIP_QW = 17;
   localparam int PROJ_DW = 55;
   localparam int PROJ_QW = 39;
   localparam int DIV_ZW  = 32;
   localparam int PROJ_LANES = 6;

   typedef struct packed {
      logic        op;
      logic        drop;
      logic        clip1;
      logic        clip2;
      logic [31:0] x1;
      logic [31:0] z1;
      logic [31:0] x2;
      logic [31:0] z2;
      logic [7:0]  front_floor;
      logic [7:0]  front_ceil;
      logic [7:0]  back_floor;
      logic [7:0]  back_ceil;
      logic [31:0] xb;
      logic [32:0] dx;
   } clip_sb_type;

   typedef struct packed {
      logic                  op;
      logic                  drop;
      logic                  fstep;
      logic                  cstep;
      logic [PROJ_LANES-1:0] neg;
   } proj_sb_type;

   function automatic logic [15:0] sat16(input logic signed [24:0] v);
      logic [15:0] r;
      if (v > 25'sd32767) begin
         r = 16'h7fff;
      end else if (v < -25'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/wall_segment_clip_project.sv @@
// Top level of the wall segment clip and project block.
// Depends on wscp_pkg and wscp_div.
//
// Usage: one wall segment enters per transaction on the req_ channel
// (valid/stall). It is clipped against the near plane, projected to screen
// columns and rows, and leaves as zero to four line transactions on the
// rsp_ channel, one per cycle while rsp_stall is low, with rsp_last on the
// final line. Segments behind the viewer, wholly off screen, or portals
// without steps produce no lines.
// The pipeline holds a 17-stage clip divider and a 39-stage projection
// divider, one quotient bit per stage. A new segment can enter every
// cycle unless the output stage holds the pipeline: it sends one line
// per cycle while rsp_stall is low, and holds the pipeline until the last
// line of a segment (four for a solid wall, up to two for a portal) is taken.
// When rsp_stall is high while a line is offered, the whole pipeline holds
// and req_stall rises; no transaction is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults. Registers are written through the csr_ APB-style port
// and must only change while the block is idle.
`default_nettype none

module wall_segment_clip_project (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_op,
   input  wire logic signed [31:0]               req_end1_x,
   input  wire logic signed [31:0]               req_end1_depth,
   input  wire logic signed [31:0]               req_end2_x,
   input  wire logic signed [31:0]               req_end2_depth,
   input  wire logic signed [7:0]                req_front_floor,
   input  wire logic signed [7:0]                req_front_ceil,
   input  wire logic signed [7:0]                req_back_floor,
   input  wire logic signed [7:0]                req_back_ceil,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [15:0]                    rsp_line_x0,
   output logic signed [15:0]                    rsp_line_y0,
   output logic signed [15:0]                    rsp_line_x1,
   output logic signed [15:0]                    rsp_line_y1,
   output logic [2:0]                            rsp_edge_kind,
   output logic                                  rsp_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [wscp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int CLIP_SW = $bits(wscp_pkg::clip_sb_type);
   localparam int PROJ_SW = $bits(wscp_pkg::proj_sb_type);
   localparam int PL      = wscp_pkg::PROJ_LANES;

   // ---------------- Configuration registers ----------------
   logic [7:0] focal_ff, center_x_ff, center_y_ff, eye_ff, near_ff;
   logic [8:0] width_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= wscp_pkg::RST_FOCAL_LENGTH;
         center_x_ff <= wscp_pkg::RST_CENTER_X;
         center_y_ff <= wscp_pkg::RST_CENTER_Y;
         width_ff    <= wscp_pkg::RST_SCREEN_WIDTH;
         eye_ff      <= wscp_pkg::RST_EYE_HEIGHT;
         near_ff     <= wscp_pkg::RST_NEAR_PLANE;
      end else if (csr_wr) begin
         unique case (csr_idx)
            wscp_pkg::REG_FOCAL_LENGTH: focal_ff    <= csr_pwdata[7:0];
            wscp_pkg::REG_CENTER_X:     center_x_ff <= csr_pwdata[7:0];
            wscp_pkg::REG_CENTER_Y:     center_y_ff <= csr_pwdata[7:0];
            wscp_pkg::REG_SCREEN_WIDTH: width_ff    <= csr_pwdata[8:0];
            wscp_pkg::REG_EYE_HEIGHT:   eye_ff      <= csr_pwdata[7:0];
            wscp_pkg::REG_NEAR_PLANE:   near_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wscp_pkg::REG_FOCAL_LENGTH: csr_prdata = {24'd0, focal_ff};
         wscp_pkg::REG_CENTER_X:     csr_prdata = {24'd0, center_x_ff};
         wscp_pkg::REG_CENTER_Y:     csr_prdata = {24'd0, center_y_ff};
         wscp_pkg::REG_SCREEN_WIDTH: csr_prdata = {23'd0, width_ff};
         wscp_pkg::REG_EYE_HEIGHT:   csr_prdata = {24'd0, eye_ff};
         wscp_pkg::REG_NEAR_PLANE:   csr_prdata = {24'd0, near_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // A near plane of zero acts as one.
   logic [23:0] near24;
   assign near24 = {((near_ff == 8'd0) ? 8'd1 : near_ff), 16'h0000};

   logic adv;
   assign req_stall = ~adv;

   // ---------------- Stage 1: input register ----------------
   logic        s1_valid_ff, s1_op_ff;
   logic [31:0] s1_x1_ff, s1_z1_ff, s1_x2_ff, s1_z2_ff;
   logic [7:0]  s1_ff_ff, s1_fc_ff, s1_bf_ff, s1_bc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff <= req_op;
         s1_x1_ff <= req_end1_x;
         s1_z1_ff <= req_end1_depth;
         s1_x2_ff <= req_end2_x;
         s1_z2_ff <= req_end2_depth;
         s1_ff_ff <= req_front_floor;
         s1_fc_ff <= req_front_ceil;
         s1_bf_ff <= req_back_floor;
         s1_bc_ff <= req_back_ceil;
      end
   end

   // ---------------- Stage 2: near plane test and clip setup ----------------
   logic signed [32:0] near_s, z1_s, z2_s, x1_s, x2_s;
   logic signed [32:0] dn1, dn2, d21, d12, dx21, dx12;
   logic               behind1, behind2;
   wscp_pkg::clip_sb_type s2_side_in, s2_side_ff;
   logic [31:0]        s2_num_in, s2_den_in, s2_num_ff, s2_den_ff;
   logic               s2_valid_ff;

   always_comb begin
      near_s  = {9'd0, near24};
      z1_s    = {s1_z1_ff[31], s1_z1_ff};
      z2_s    = {s1_z2_ff[31], s1_z2_ff};
      x1_s    = {s1_x1_ff[31], s1_x1_ff};
      x2_s    = {s1_x2_ff[31], s1_x2_ff};
      behind1 = (z1_s < near_s);
      behind2 = (z2_s < near_s);
      dn1     = near_s - z1_s;
      dn2     = near_s - z2_s;
      d21     = z2_s - z1_s;
      d12     = z1_s - z2_s;
      dx21    = x2_s - x1_s;
      dx12    = x1_s - x2_s;

      s2_side_in.op          = s1_op_ff;
      s2_side_in.drop        = behind1 & behind2;
      s2_side_in.clip1       = behind1 & ~behind2;
      s2_side_in.clip2       = ~behind1 & behind2;
      s2_side_in.x1          = s1_x1_ff;
      s2_side_in.z1          = s1_z1_ff;
      s2_side_in.x2          = s1_x2_ff;
      s2_side_in.z2          = s1_z2_ff;
      s2_side_in.front_floor = s1_ff_ff;
      s2_side_in.front_ceil  = s1_fc_ff;
      s2_side_in.back_floor  = s1_bf_ff;
      s2_side_in.back_ceil   = s1_bc_ff;
      s2_side_in.xb          = behind1 ? s1_x1_ff : s1_x2_ff;
      s2_side_in.dx          = behind1 ? dx21 : dx12;

      // Without a clip the divider gets a harmless zero over one.
      if (s2_side_in.clip1) begin
         s2_num_in = dn1[31:0];
         s2_den_in = d21[31:0];
      end else if (s2_side_in.clip2) begin
         s2_num_in = dn2[31:0];
         s2_den_in = d12[31:0];
      end else begin
         s2_num_in = 32'd0;
         s2_den_in = 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff <= s2_side_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   // ---------------- Clip fraction divider ----------------
   logic [0:0][wscp_pkg::CLIP_DW-1:0] clip_dividend;
   logic [0:0][wscp_pkg::DIV_ZW-1:0]  clip_divisor;
   logic [0:0][wscp_pkg::CLIP_QW-1:0] clip_quot;
   logic [CLIP_SW-1:0]                clip_side_out;
   logic                              clip_valid;
   wscp_pkg::clip_sb_type             clip_side;

   assign clip_dividend[0] = {s2_num_ff, 16'h0000};
   assign clip_divisor[0]  = s2_den_ff;
   assign clip_side        = wscp_pkg::clip_sb_type'(clip_side_out);

   wscp_div #(
      .LANES (1),
      .DW    (wscp_pkg::CLIP_DW),
      .QW    (wscp_pkg::CLIP_QW),
      .ZW    (wscp_pkg::DIV_ZW),
      .SW    (CLIP_SW)
   ) u_clip_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (s2_valid_ff),
      .in_dividend  (clip_dividend),
      .in_divisor   (clip_divisor),
      .in_side      (s2_side_ff),
      .out_valid    (clip_valid),
      .out_quotient (clip_quot),
      .out_side     (clip_side_out)
   );

   // ---------------- Stage 3: interpolation product ----------------
   logic signed [50:0]    s3_prod_in, s3_prod_ff;
   wscp_pkg::clip_sb_type s3_side_ff;
   logic                  s3_valid_ff;

   assign s3_prod_in = $signed({1'b0, clip_quot[0]}) * $signed(clip_side.dx);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= clip_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_prod_ff <= s3_prod_in;
         s3_side_ff <= clip_side;
      end
   end

   // ---------------- Stage 4: clipped endpoints ----------------
   logic [34:0] xsum;
   logic [31:0] s4_x1_in, s4_z1_in, s4_x2_in, s4_z2_in;
   logic [31:0] s4_x1_ff, s4_z1_ff, s4_x2_ff, s4_z2_ff;
   logic [7:0]  s4_ha_in, s4_hb_in, s4_ha_ff, s4_hb_ff;
   logic        s4_fstep_in, s4_cstep_in;
   logic        s4_valid_ff, s4_op_ff, s4_drop_ff, s4_fstep_ff, s4_cstep_ff;

   always_comb begin
      xsum     = {{3{s3_side_ff.xb[31]}}, s3_side_ff.xb} + s3_prod_ff[50:16];
      s4_x1_in = s3_side_ff.clip1 ? xsum[31:0] : s3_side_ff.x1;
      s4_z1_in = s3_side_ff.clip1 ? {8'd0, near24} : s3_side_ff.z1;
      s4_x2_in = s3_side_ff.clip2 ? xsum[31:0] : s3_side_ff.x2;
      s4_z2_in = s3_side_ff.clip2 ? {8'd0, near24} : s3_side_ff.z2;
      s4_fstep_in = ($signed(s3_side_ff.back_floor) > $signed(s3_side_ff.front_floor));
      s4_cstep_in = ($signed(s3_side_ff.back_ceil) < $signed(s3_side_ff.front_ceil));
      // Solid walls project ceiling and floor; portals the back heights.
      if (s3_side_ff.op == wscp_pkg::OP_SOLID) begin
         s4_ha_in = s3_side_ff.front_ceil;
         s4_hb_in = s3_side_ff.front_floor;
      end else begin
         s4_ha_in = s3_side_ff.back_floor;
         s4_hb_in = s3_side_ff.back_ceil;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_x1_ff    <= s4_x1_in;
         s4_z1_ff    <= s4_z1_in;
         s4_x2_ff    <= s4_x2_in;
         s4_z2_ff    <= s4_z2_in;
         s4_ha_ff    <= s4_ha_in;
         s4_hb_ff    <= s4_hb_in;
         s4_op_ff    <= s3_side_ff.op;
         s4_drop_ff  <= s3_side_ff.drop;
         s4_fstep_ff <= s4_fstep_in;
         s4_cstep_ff <= s4_cstep_in;
      end
   end

   // ---------------- Stage 5: magnitudes and signs ----------------
   logic [8:0]  rel_a, rel_b, arel_a, arel_b;
   logic [31:0] ax1_in, ax2_in;
   logic [31:0] s5_ax1_ff, s5_ax2_ff, s5_z1_ff, s5_z2_ff;
   logic [7:0]  s5_arel_a_ff, s5_arel_b_ff;
   wscp_pkg::proj_sb_type s5_side_in, s5_side_ff;
   logic        s5_valid_ff;

   always_comb begin
      rel_a  = {s4_ha_ff[7], s4_ha_ff} - {eye_ff[7], eye_ff};
      rel_b  = {s4_hb_ff[7], s4_hb_ff} - {eye_ff[7], eye_ff};
      arel_a = rel_a[8] ? (9'd0 - rel_a) : rel_a;
      arel_b = rel_b[8] ? (9'd0 - rel_b) : rel_b;
      ax1_in = s4_x1_ff[31] ? (32'd0 - s4_x1_ff) : s4_x1_ff;
      ax2_in = s4_x2_ff[31] ? (32'd0 - s4_x2_ff) : s4_x2_ff;
      s5_side_in.op    = s4_op_ff;
      s5_side_in.drop  = s4_drop_ff;
      s5_side_in.fstep = s4_fstep_ff;
      s5_side_in.cstep = s4_cstep_ff;
      s5_side_in.neg   = {rel_b[8], rel_a[8], rel_b[8], rel_a[8], s4_x2_ff[31], s4_x1_ff[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ax1_ff    <= ax1_in;
         s5_ax2_ff    <= ax2_in;
         s5_arel_a_ff <= arel_a[7:0];
         s5_arel_b_ff <= arel_b[7:0];
         s5_z1_ff     <= s4_z1_ff;
         s5_z2_ff     <= s4_z2_ff;
         s5_side_ff   <= s5_side_in;
      end
   end

   // ---------------- Stage 6: scale by focal length ----------------
   logic [39:0] acol1, acol2;
   logic [15:0] arow_a, arow_b;
   logic [PL-1:0][wscp_pkg::PROJ_DW-1:0] s6_dividend_in, s6_dividend_ff;
   logic [PL-1:0][wscp_pkg::DIV_ZW-1:0]  s6_divisor_in, s6_divisor_ff;
   wscp_pkg::proj_sb_type s6_side_ff;
   logic        s6_valid_ff;

   always_comb begin
      acol1  = {8'd0, s5_ax1_ff} * {32'd0, focal_ff};
      acol2  = {8'd0, s5_ax2_ff} * {32'd0, focal_ff};
      arow_a = {8'd0, s5_arel_a_ff} * {8'd0, focal_ff};
      arow_b = {8'd0, s5_arel_b_ff} * {8'd0, focal_ff};
      // Lanes: columns of both ends, then first-end rows, then second-end rows.
      s6_dividend_in[0] = {acol1[38:0], 16'h0000};
      s6_dividend_in[1] = {acol2[38:0], 16'h0000};
      s6_dividend_in[2] = {7'd0, arow_a, 32'h0};
      s6_dividend_in[3] = {7'd0, arow_b, 32'h0};
      s6_dividend_in[4] = {7'd0, arow_a, 32'h0};
      s6_dividend_in[5] = {7'd0, arow_b, 32'h0};
      s6_divisor_in[0]  = s5_z1_ff;
      s6_divisor_in[1]  = s5_z2_ff;
      s6_divisor_in[2]  = s5_z1_ff;
      s6_divisor_in[3]  = s5_z1_ff;
      s6_divisor_in[4]  = s5_z2_ff;
      s6_divisor_in[5]  = s5_z2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_dividend_ff <= s6_dividend_in;
         s6_divisor_ff  <= s6_divisor_in;
         s6_side_ff     <= s5_side_ff;
      end
   end

   // ---------------- Projection divider ----------------
   logic [PL-1:0][wscp_pkg::PROJ_QW-1:0] proj_quot;
   logic [PROJ_SW-1:0]                   proj_side_out;
   logic                                 proj_valid;
   wscp_pkg::proj_sb_type                proj_side;

   assign proj_side = wscp_pkg::proj_sb_type'(proj_side_out);

   wscp_div #(
      .LANES (PL),
      .DW    (wscp_pkg::PROJ_DW),
      .QW    (wscp_pkg::PROJ_QW),
      .ZW    (wscp_pkg::DIV_ZW),
      .SW    (PROJ_SW)
   ) u_proj_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (s6_valid_ff),
      .in_dividend  (s6_dividend_ff),
      .in_divisor   (s6_divisor_ff),
      .in_side      (s6_side_ff),
      .out_valid    (proj_valid),
      .out_quotient (proj_quot),
      .out_side     (proj_side_out)
   );

   // ---------------- Stage 7: sign and floor ----------------
   // The quotient truncates toward zero; dropping 16 bits of the signed value floors it.
   logic [39:0] q40 [PL];
   logic [23:0] s7_fl_ff [PL];
   wscp_pkg::proj_sb_type s7_side_ff;
   logic        s7_valid_ff;

   always_comb begin
      for (int l = 0; l < PL; l++) begin
         q40[l] = proj_side.neg[l] ? (40'd0 - {1'b0, proj_quot[l]}) : {1'b0, proj_quot[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= proj_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < PL; l++) begin
            s7_fl_ff[l] <= q40[l][39:16];
         end
         s7_side_ff <= proj_side;
      end
   end

   // ---------------- Stage 8: screen coordinates ----------------
   logic signed [24:0] s8_sx1_ff, s8_sx2_ff, s8_ya1_ff, s8_yb1_ff, s8_ya2_ff, s8_yb2_ff;
   logic [24:0]        cx25, cy25;
   wscp_pkg::proj_sb_type s8_side_ff;
   logic               s8_valid_ff;

   assign cx25 = {17'd0, center_x_ff};
   assign cy25 = {17'd0, center_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_sx1_ff  <= cx25 + {s7_fl_ff[0][23], s7_fl_ff[0]};
         s8_sx2_ff  <= cx25 + {s7_fl_ff[1][23], s7_fl_ff[1]};
         s8_ya1_ff  <= cy25 - {s7_fl_ff[2][23], s7_fl_ff[2]};
         s8_yb1_ff  <= cy25 - {s7_fl_ff[3][23], s7_fl_ff[3]};
         s8_ya2_ff  <= cy25 - {s7_fl_ff[4][23], s7_fl_ff[4]};
         s8_yb2_ff  <= cy25 - {s7_fl_ff[5][23], s7_fl_ff[5]};
         s8_side_ff <= s7_side_ff;
      end
   end

   // ---------------- Output stage: reject, saturate, send lines ----------------
   logic signed [24:0] width_s;
   logic               reject;
   logic [2:0]         cnt_in;
   logic               o_valid_ff, o_op_ff, o_fstep_ff;
   logic [2:0]         o_cnt_ff;
   logic [1:0]         o_idx_ff;
   logic [15:0]        o_sx1_ff, o_sx2_ff, o_ya1_ff, o_yb1_ff, o_ya2_ff, o_yb2_ff;
   logic               o_last;
   logic               sel_b;

   always_comb begin
      width_s = {16'd0, width_ff};
      reject  = (s8_sx1_ff[24] && s8_sx2_ff[24]) ||
                ((s8_sx1_ff >= width_s) && (s8_sx2_ff >= width_s));
      if (s8_side_ff.drop || reject) begin
         cnt_in = 3'd0;
      end else if (s8_side_ff.op == wscp_pkg::OP_SOLID) begin
         cnt_in = 3'd4;
      end else begin
         cnt_in = {2'd0, s8_side_ff.fstep} + {2'd0, s8_side_ff.cstep};
      end
   end

   assign rsp_valid = o_valid_ff && (o_cnt_ff != 3'd0);
   assign o_last    = ({1'b0, o_idx_ff} == (o_cnt_ff - 3'd1));
   // A held transaction with no lines frees the stage at once.
   assign adv       = ~o_valid_ff || (o_cnt_ff == 3'd0) || (~rsp_stall && o_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_idx_ff   <= 2'd0;
      end else if (adv) begin
         o_valid_ff <= s8_valid_ff;
         o_idx_ff   <= 2'd0;
      end else if (rsp_valid && ~rsp_stall) begin
         o_idx_ff   <= o_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_cnt_ff   <= cnt_in;
         o_op_ff    <= s8_side_ff.op;
         o_fstep_ff <= s8_side_ff.fstep;
         o_sx1_ff   <= wscp_pkg::sat16(s8_sx1_ff);
         o_sx2_ff   <= wscp_pkg::sat16(s8_sx2_ff);
         o_ya1_ff   <= wscp_pkg::sat16(s8_ya1_ff);
         o_yb1_ff   <= wscp_pkg::sat16(s8_yb1_ff);
         o_ya2_ff   <= wscp_pkg::sat16(s8_ya2_ff);
         o_yb2_ff   <= wscp_pkg::sat16(s8_yb2_ff);
      end
   end

   // A portal's first line is the floor step if there is one.
   assign sel_b    = o_idx_ff[0] || ~o_fstep_ff;
   assign rsp_last = o_last;

   always_comb begin
      if (o_op_ff == wscp_pkg::OP_SOLID) begin
         unique case (o_idx_ff)
            2'd0: begin
               rsp_line_x0 = o_sx1_ff; rsp_line_y0 = o_ya1_ff;
               rsp_line_x1 = o_sx2_ff; rsp_line_y1 = o_ya2_ff;
               rsp_edge_kind = wscp_pkg::KIND_CEILING;
            end
            2'd1: begin
               rsp_line_x0 = o_sx1_ff; rsp_line_y0 = o_yb1_ff;
               rsp_line_x1 = o_sx2_ff; rsp_line_y1 = o_yb2_ff;
               rsp_edge_kind = wscp_pkg::KIND_FLOOR;
            end
            2'd2: begin
               rsp_line_x0 = o_sx1_ff; rsp_line_y0 = o_ya1_ff;
               rsp_line_x1 = o_sx1_ff; rsp_line_y1 = o_yb1_ff;
               rsp_edge_kind = wscp_pkg::KIND_LEFT;
            end
            default: begin
               rsp_line_x0 = o_sx2_ff; rsp_line_y0 = o_ya2_ff;
               rsp_line_x1 = o_sx2_ff; rsp_line_y1 = o_yb2_ff;
               rsp_edge_kind = wscp_pkg::KIND_RIGHT;
            end
         endcase
      end else if (sel_b) begin
         rsp_line_x0 = o_sx1_ff; rsp_line_y0 = o_yb1_ff;
         rsp_line_x1 = o_sx2_ff; rsp_line_y1 = o_yb2_ff;
         rsp_edge_kind = wscp_pkg::KIND_CEIL_STEP;
      end else begin
         rsp_line_x0 = o_sx1_ff; rsp_line_y0 = o_ya1_ff;
         rsp_line_x1 = o_sx2_ff; rsp_line_y1 = o_ya2_ff;
         rsp_edge_kind = wscp_pkg::KIND_FLOOR_STEP;
      end
   end

endmodule

`default_nettype wire

@@ rtl/wscp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
// Carries a sideband word alongside the lanes. No package dependency.
`default_nettype none

module wscp_div #(
   parameter int LANES = 1,
   parameter int DW    = 48,
   parameter int QW    = 17,
   parameter int ZW    = 32,
   parameter int SW    = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       enable,
   input  wire logic                       in_valid,
   input  wire logic [LANES-1:0][DW-1:0]   in_dividend,
   input  wire logic [LANES-1:0][ZW-1:0]   in_divisor,
   input  wire logic [SW-1:0]              in_side,
   output logic                            out_valid,
   output logic [LANES-1:0][QW-1:0]        out_quotient,
   output logic [SW-1:0]                   out_side
);

   // The dividend must be below divisor * 2^QW, so its top bits start as remainder.
   logic [ZW-1:0]    r_ff   [QW][LANES];
   logic [ZW-1:0]    r_in   [QW][LANES];
   logic [ZW-1:0]    r_src  [QW][LANES];
   logic [QW-1:0]    lq_ff  [QW][LANES];
   logic [QW-1:0]    lq_in  [QW][LANES];
   logic [QW-1:0]    lq_src [QW][LANES];
   logic [ZW-1:0]    z_ff   [QW][LANES];
   logic [ZW-1:0]    z_src  [QW][LANES];
   logic [ZW:0]      trial  [QW][LANES];
   logic [ZW:0]      diff   [QW][LANES];
   logic [LANES-1:0] ge     [QW];
   logic [QW-1:0]    valid_ff;
   logic [SW-1:0]    side_ff [QW];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         r_src[0][l]  = ZW'(in_dividend[l][DW-1:QW]);
         lq_src[0][l] = in_dividend[l][QW-1:0];
         z_src[0][l]  = in_divisor[l];
      end
      for (int k = 1; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            r_src[k][l]  = r_ff[k-1][l];
            lq_src[k][l] = lq_ff[k-1][l];
            z_src[k][l]  = z_ff[k-1][l];
         end
      end
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial[k][l] = {r_src[k][l], lq_src[k][l][QW-1]};
            diff[k][l]  = trial[k][l] - {1'b0, z_src[k][l]};
            ge[k][l]    = (trial[k][l] >= {1'b0, z_src[k][l]});
            r_in[k][l]  = ge[k][l] ? diff[k][l][ZW-1:0] : trial[k][l][ZW-1:0];
            lq_in[k][l] = {lq_src[k][l][QW-2:0], ge[k][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < QW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < LANES; l++) begin
               r_ff[k][l]  <= r_in[k][l];
               lq_ff[k][l] <= lq_in[k][l];
               z_ff[k][l]  <= z_src[k][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quotient[l] = lq_ff[QW-1][l];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire
